>>> sv/ssrch_pkg.sv
package ssrch_pkg;

   // fixed field widths
   localparam int BYTE_W     = 8;
   localparam int PAT_BYTES  = 16;
   localparam int PAT_IDX_W  = 4;
   localparam int PLEN_W     = 5;
   localparam int COUNT_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // saturation point of the text byte count
   localparam logic [COUNT_W-1:0] TEXT_MAX = 16'd65535;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 2'd2;

   // one text transaction held in the input register
   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              text_empty;
      logic              last;
   } req_item_type;

   // one search result
   typedef struct packed {
      logic [COUNT_W-1:0] position;
      logic               overflow;
   } rsp_item_type;

endpackage

>>> sv/ssrch_req_if.sv
interface ssrch_req_if
   import ssrch_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              text_empty;
   logic              last;

   modport source (output valid, output text_byte, output text_empty, output last,
                   input ready);
   modport sink (input valid, input text_byte, input text_empty, input last,
                 output ready);
endinterface

>>> sv/ssrch_rsp_if.sv
interface ssrch_rsp_if
   import ssrch_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] position;
   logic               overflow;

   modport source (output valid, output position, output overflow, input ready);
   modport sink (input valid, input position, input overflow, output ready);
endinterface

>>> sv/ssrch_match.sv
module ssrch_match
   import ssrch_pkg::*;
#(
   parameter int PATTERN_MAX = 16,
   parameter int WIN_DEPTH   = 15,
   parameter int LEN_W       = 5
) (
   input  logic [BYTE_W-1:0]                text_byte,
   input  logic [BYTE_W-1:0]                window [WIN_DEPTH],
   input  logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern,
   input  logic [LEN_W-1:0]                 pat_len,
   output logic                             equal
);

   // compare the text byte and the window slots within the pattern length against the pattern byte aligned to each
   always_comb begin
      logic [PLEN_W-1:0] d;
      logic              mismatch;
      d = PLEN_W'(pat_len) - 5'd1;
      mismatch = (pat_len != '0) && (text_byte != pattern[d[PAT_IDX_W-1:0]]);
      for (int j = 1; j < PATTERN_MAX; j++) begin
         d = PLEN_W'(pat_len) - PLEN_W'(j) - 5'd1;
         if ((PLEN_W'(j) < PLEN_W'(pat_len)) &&
             (window[j-1] != pattern[d[PAT_IDX_W-1:0]])) begin
            mismatch = 1'b1;
         end
      end
      equal = !mismatch;
   end

endmodule

>>> sv/substring_position_search.sv
// channel | dir | handshake             | payload
// req_ch  | in  | valid/ready           | text_byte[7:0], text_empty, last
// rsp_ch  | out | valid/ready           | position[15:0], overflow
// csr     | in  | csr_we (no handshake) | csr_index[1:0], csr_wdata[63:0]
//
// one text byte per cycle while req_ch.ready is high; an end-of-text transaction goes from
// the input register through compare and state update into the result register
// the single window compare and count update lie between the two registers
// reset is synchronous, active high, and clears pattern, window, count and match state
// req_ch.ready drops only while an end-of-text transaction waits on a full result register
module substring_position_search
   import ssrch_pkg::*;
#(
   parameter int PATTERN_MAX = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   ssrch_req_if.sink             req_ch,
   ssrch_rsp_if.source           rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
   localparam int LEN_W     = $clog2(PATTERN_MAX + 1);

   // configuration registers
   logic [CSR_DATA_W-1:0] pat_low_ff, pat_high_ff;
   logic [PLEN_W-1:0]     pat_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_wdata;
            CSR_PATTERN_LEN:  pat_len_ff  <= csr_wdata[PLEN_W-1:0];
            default: ;
         endcase
      end
   end

   logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
   logic [LEN_W-1:0]                 len_eff;

   assign pattern = {pat_high_ff, pat_low_ff};
   assign len_eff = (pat_len_ff > PLEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                        : pat_len_ff[LEN_W-1:0];

   // input register
   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         s1_ends, s1_go, out_free;

   assign s1_ends      = s1_item_ff.text_empty || s1_item_ff.last;
   assign out_free     = !rsp_ch.valid || rsp_ch.ready;
   assign s1_go        = s1_valid_ff && (!s1_ends || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_item_ff.text_byte  <= req_ch.text_byte;
         s1_item_ff.text_empty <= req_ch.text_empty;
         s1_item_ff.last       <= req_ch.last;
      end
   end

   // per-text search state
   logic [BYTE_W-1:0]  win_ff [WIN_DEPTH];
   logic [BYTE_W-1:0]  win_in [WIN_DEPTH];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               found_ff, found_in;
   logic [COUNT_W-1:0] start_ff, start_in;
   logic               ovf_ff, ovf_in;
   logic               win_equal;

   ssrch_match #(
      .PATTERN_MAX (PATTERN_MAX),
      .WIN_DEPTH   (WIN_DEPTH),
      .LEN_W       (LEN_W)
   ) u_match (
      .text_byte (s1_item_ff.text_byte),
      .window    (win_ff),
      .pattern   (pattern),
      .pat_len   (len_eff),
      .equal     (win_equal)
   );

   // next state for the byte in the input register
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      found_in = found_ff;
      start_in = start_ff;
      win_in   = win_ff;
      if (!s1_item_ff.text_empty) begin
         if (count_ff >= TEXT_MAX) begin
            count_in = TEXT_MAX;
            ovf_in   = 1'b1;
         end else begin
            count_in = count_ff + 16'd1;
         end
         if (!found_ff && (len_eff != '0) && (count_in >= COUNT_W'(len_eff)) && win_equal)
         begin
            found_in = 1'b1;
            start_in = count_in - COUNT_W'(len_eff) + 16'd1;
         end
         win_in[0] = s1_item_ff.text_byte;
         for (int k = 1; k < WIN_DEPTH; k++) begin
            win_in[k] = win_ff[k-1];
         end
      end
   end

   // state update, cleared at end of text
   always_ff @(posedge clock) begin
      if (reset || (s1_go && s1_ends)) begin
         count_ff <= '0;
         found_ff <= 1'b0;
         start_ff <= '0;
         ovf_ff   <= 1'b0;
         for (int k = 0; k < WIN_DEPTH; k++) begin
            win_ff[k] <= '0;
         end
      end else if (s1_go) begin
         count_ff <= count_in;
         found_ff <= found_in;
         start_ff <= start_in;
         ovf_ff   <= ovf_in;
         win_ff   <= win_in;
      end
   end

   // result register
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   always_comb begin
      if (len_eff == '0) begin
         rsp_item_in.position = 16'd1;
      end else if (found_in) begin
         rsp_item_in.position = start_in;
      end else begin
         rsp_item_in.position = '0;
      end
      rsp_item_in.overflow = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_ends) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_ends) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.position = rsp_item_ff.position;
   assign rsp_ch.overflow = rsp_item_ff.overflow;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= TEXT_MAX)
      else $error("byte count above saturation point");

   a_start_range: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (start_ff != '0 && start_ff <= count_ff))
      else $error("recorded match start outside the bytes seen");

   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == TEXT_MAX))
      else $error("overflow flagged without saturated count");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_ends) |=> (count_ff == '0 && !found_ff && !ovf_ff && rsp_valid_ff))
      else $error("end of text did not clear state or post a result");
`endif

endmodule

>>> tb/sv/substring_position_search_tb.sv
`timescale 1ns / 1ps

module substring_position_search_tb;
   import ssrch_pkg::*;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ssrch_req_if req_if ();
   ssrch_rsp_if rsp_if ();

   substring_position_search u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock generation
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // pending text transactions and expected search results
   req_item_type text_queue[$];
   rsp_item_type position_results[$];

   // idling control, set per phase
   bit send_gaps;
   bit sink_stalls;
   int gap_left;
   int stall_left;
   int mismatches;

   // search model: pattern registers and per-text state
   logic [63:0] pat_low;
   logic [63:0] pat_high;
   logic [4:0]  pat_len;
   logic [7:0]  recent_bytes [0:14];
   logic [15:0] text_count;
   logic        found_match;
   logic [15:0] found_start;
   logic        count_saturated;

   function automatic int eff_len();
      return (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
   endfunction

   function automatic logic [7:0] pattern_at(int k);
      logic [127:0] whole;
      whole = {pat_high, pat_low};
      return whole[8*k +: 8];
   endfunction

   function automatic void clear_text_state();
      for (int j = 0; j < 15; j++) recent_bytes[j] = 8'd0;
      text_count      = 16'd0;
      found_match     = 1'b0;
      found_start     = 16'd0;
      count_saturated = 1'b0;
   endfunction

   // advance the search by one accepted transaction
   function automatic void search_step(logic [7:0] text_byte, logic text_empty,
                                       logic last_flag);
      int           len;
      bit           hit;
      logic [7:0]   seen;
      rsp_item_type res;
      len = eff_len();
      if (!text_empty) begin
         if (text_count == TEXT_MAX) begin
            count_saturated = 1'b1;
         end else begin
            text_count++;
         end
         // window compare, current byte against the last pattern byte, earlier bytes against the ones before it
         if (!found_match && len > 0 && text_count >= len) begin
            hit = 1'b1;
            for (int j = 0; j < len; j++) begin
               seen = (j == 0) ? text_byte : recent_bytes[j-1];
               if (seen != pattern_at(len - 1 - j)) hit = 1'b0;
            end
            if (hit) begin
               found_match = 1'b1;
               found_start = text_count - 16'(len) + 16'd1;
            end
         end
         for (int j = 14; j > 0; j--) recent_bytes[j] = recent_bytes[j-1];
         recent_bytes[0] = text_byte;
      end
      if (text_empty || last_flag) begin
         if (len == 0) begin
            res.position = 16'd1;
         end else begin
            res.position = found_match ? found_start : 16'd0;
         end
         res.overflow = count_saturated;
         position_results.push_back(res);
         clear_text_state();
      end
   endfunction

   // driver: presents queued transactions, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            search_step(req_if.text_byte, req_if.text_empty, req_if.last);
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (send_gaps && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 19) - 1;
               req_if.valid <= 1'b0;
            end else if (text_queue.size() > 0) begin
               req_if.text_byte  <= text_queue[0].text_byte;
               req_if.text_empty <= text_queue[0].text_empty;
               req_if.last       <= text_queue[0].last;
               req_if.valid      <= 1'b1;
               void'(text_queue.pop_front());
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks results against the oldest prediction, stalls at random
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (position_results.size() == 0) begin
               mismatches++;
               if (mismatches < 50)
                  $display("%0t: unexpected result position %0d overflow %0b", $time,
                           rsp_if.position, rsp_if.overflow);
            end else begin
               want = position_results.pop_front();
               if (rsp_if.position !== want.position) begin
                  mismatches++;
                  if (mismatches < 50)
                     $display("%0t: position expected %0d actual %0d", $time,
                              want.position, rsp_if.position);
               end
               if (rsp_if.overflow !== want.overflow) begin
                  mismatches++;
                  if (mismatches < 50)
                     $display("%0t: overflow expected %0b actual %0b", $time,
                              want.overflow, rsp_if.overflow);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_PATTERN_LOW:  pat_low  = data;
         CSR_PATTERN_HIGH: pat_high = data;
         CSR_PATTERN_LEN:  pat_len  = data[PLEN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_pattern(logic [63:0] low, logic [63:0] high, logic [4:0] len);
      csr_write(CSR_PATTERN_LOW, low);
      csr_write(CSR_PATTERN_HIGH, high);
      csr_write(CSR_PATTERN_LEN, {59'd0, len});
   endtask

   // block the sender until nothing is queued, in flight or expected
   task automatic wait_for_idle();
      @(negedge clock);
      while (text_queue.size() != 0 || req_if.valid || position_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic void push_byte(logic [7:0] b, logic last_flag);
      req_item_type t;
      t.text_byte  = b;
      t.text_empty = 1'b0;
      t.last       = last_flag;
      text_queue.push_back(t);
   endfunction

   // text_byte and last are don't-care on an empty transaction
   function automatic void push_empty();
      req_item_type t;
      t.text_byte  = 8'($urandom);
      t.text_empty = 1'b1;
      t.last       = 1'($urandom);
      text_queue.push_back(t);
   endfunction

   function automatic logic [63:0] pattern_word(int mode);
      logic [63:0] w;
      case (mode)
         0: w = '0;
         1: w = '1;
         2: for (int k = 0; k < 8; k++) w[8*k +: 8] = 8'h5A + 8'($urandom_range(0, 2));
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   // well-formed texts built around the current pattern, with some noise
   task automatic random_texts(int budget);
      logic [7:0] body[$];
      int len, span, off;
      while (budget > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            push_empty();
            budget--;
         end else begin
            len  = eff_len();
            span = $urandom_range(0, len + 10);
            body.delete();
            for (int i = 0; i < span; i++) begin
               if ($urandom_range(0, 3) == 0 || len == 0)
                  body.push_back(8'($urandom));
               else
                  body.push_back(pattern_at($urandom_range(0, len - 1)));
            end
            if ($urandom_range(0, 1) == 1) begin
               off = $urandom_range(0, body.size());
               for (int k = len - 1; k >= 0; k--) body.insert(off, pattern_at(k));
            end
            if (body.size() == 0) begin
               push_empty();
               budget--;
            end else if ($urandom_range(0, 7) == 0) begin
               // text closed by an empty transaction instead of last
               foreach (body[i]) push_byte(body[i], 1'b0);
               push_empty();
               budget -= body.size() + 1;
            end else begin
               foreach (body[i]) push_byte(body[i], i == body.size() - 1);
               budget -= body.size();
            end
         end
      end
   endtask

   // stimulus
   initial begin
      logic [63:0] rnd_low, rnd_high;
      logic [4:0]  rnd_len;
      int          pick;
      req_if.valid      = 1'b0;
      req_if.text_byte  = 8'd0;
      req_if.text_empty = 1'b0;
      req_if.last       = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_PATTERN_LOW;
      csr_wdata         = '0;
      pat_low           = '0;
      pat_high          = '0;
      pat_len           = '0;
      mismatches        = 0;
      send_gaps         = 1'b1;
      sink_stalls       = 1'b1;
      clear_text_state();
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty pattern after reset, empty text
      push_empty();
      wait_for_idle();

      // three byte pattern with extreme byte values
      set_pattern(64'h0000_0000_0080_FF00, 64'd0, 5'd3);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h80, 1'b1);
      // pattern longer than the text, text ended by an empty transaction
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_empty();
      // pattern changed in the middle of a text
      push_byte(8'h11, 1'b0);
      push_byte(8'h22, 1'b0);
      wait_for_idle();
      set_pattern(64'h0000_0000_0000_4433, 64'd0, 5'd2);
      push_byte(8'h33, 1'b0);
      push_byte(8'h44, 1'b1);
      wait_for_idle();

      // length above the maximum, full sixteen byte match
      set_pattern({$urandom, $urandom}, {$urandom, $urandom}, 5'd31);
      for (int k = 0; k < PAT_BYTES; k++) push_byte(pattern_at(k), k == PAT_BYTES - 1);
      wait_for_idle();

      // random phases, mixing idling styles
      for (int phase = 0; phase < 8; phase++) begin
         send_gaps   = (phase % 3) != 2;
         sink_stalls = (phase % 3) != 1;
         if (phase == 7) begin
            // final phase runs with no idling on either side
            send_gaps   = 1'b0;
            sink_stalls = 1'b0;
         end
         pick = $urandom_range(0, 3);
         if (phase == 0) begin
            set_pattern(64'd0, 64'd0, 5'd16);
         end else if (phase == 1) begin
            set_pattern('1, '1, 5'd31);
         end else begin
            rnd_low  = pattern_word(pick);
            rnd_high = pattern_word($urandom_range(0, 3));
            case ($urandom_range(0, 3))
               0:       rnd_len = 5'($urandom_range(0, 31));
               1:       rnd_len = 5'd16;
               default: rnd_len = 5'($urandom_range(1, 6));
            endcase
            set_pattern(rnd_low, rnd_high, rnd_len);
         end
         random_texts(88);
         wait_for_idle();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
